/* design/bsel_pkg.sv */
// Shared types, codes and a helper function for the backend selector.
package bsel_pkg;

  // Default sizes for the top-level parameters.
  localparam int MAX_BACKENDS_DEF = 8;
  localparam int WEIGHT_WIDTH_DEF = 8;
  localparam int COUNT_WIDTH_DEF  = 16;

  // Fixed field widths.
  localparam int INDEX_W = 3;   // backend_index and selected_backend
  localparam int LIVE_W  = 4;   // backend_count, walk counter, pointer
  localparam int SLOT_W  = 8;   // one weight slot in the weight table
  localparam int TABLE_W = 64;  // the packed weight table
  localparam int SCORE_W = 16;  // running score of smooth weighted round robin
  localparam int SUM_W   = 18;  // score plus or minus one weight or the total
  localparam int TOTAL_W = 12;  // sum of up to fifteen 8-bit weights
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS = 2'd2;

  // Policy codes; the unused code behaves as round robin.
  localparam logic [1:0] POL_RR       = 2'd0;
  localparam logic [1:0] POL_WEIGHTED = 2'd1;
  localparam logic [1:0] POL_LEAST    = 2'd2;

  typedef enum logic [1:0] {
    CMD_PICK      = 2'd0,
    CMD_RELEASE   = 2'd1,
    CMD_MARK_DOWN = 2'd2,
    CMD_MARK_UP   = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_BACKENDS = 2'd1,
    ST_NO_HEALTHY  = 2'd2
  } status_t;

  typedef struct packed {
    command_t           command;
    logic [INDEX_W-1:0] backend_index;
  } request_t;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] selected_backend;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RR_SCAN,
    S_WALK,
    S_INC_RD,
    S_INC_WR,
    S_REL_RD,
    S_REL_WR
  } state_t;

  // Clamp a widened sum back into the signed score range.
  function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [SUM_W-1:0] v);
    logic fits;
    fits = (v[SUM_W-1:SCORE_W-1] == '0) || (v[SUM_W-1:SCORE_W-1] == '1);
    if (fits) begin
      return v[SCORE_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(SCORE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SCORE_W-1){1'b1}}};
    end
  endfunction

endpackage

/* design/backend_selector.sv */
// Backend selector: round robin, smooth weighted round robin and least connections.
//
// One command beat is taken when start is high and busy is low; exactly one result
// beat follows on result, marked by done for a single cycle, and the receiver cannot
// hold it off. Health commands finish in the dispatch state, releases after a read and
// a write of the connection memory. A round robin pick scans the n backends in use
// from the pointer and stops early when a healthy entry is found; the weighted and
// least-connection policies have a sequencer walk the backend entries one per cycle
// against the score and connection memories. busy stays high for the whole item.
// Scores and connection counts start at zero after reset without a clearing pass.
module backend_selector #(
  parameter int MAX_BACKENDS = bsel_pkg::MAX_BACKENDS_DEF,
  parameter int WEIGHT_WIDTH = bsel_pkg::WEIGHT_WIDTH_DEF,
  parameter int COUNT_WIDTH  = bsel_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  bsel_pkg::request_t                    request,
  output logic                                  done,
  output bsel_pkg::result_t                     result,
  input  logic                                  cfg_write,
  input  logic [bsel_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bsel_pkg::TABLE_W-1:0]          cfg_data
);
  import bsel_pkg::*;

  localparam int IDX_W = $clog2(MAX_BACKENDS);
  localparam logic [SLOT_W-1:0] WMASK =
    (WEIGHT_WIDTH >= SLOT_W) ? {SLOT_W{1'b1}} : SLOT_W'((1 << WEIGHT_WIDTH) - 1);

  // Configuration registers.
  logic [1:0]         policy_mode;
  logic [LIVE_W-1:0]  backend_count;
  logic [TABLE_W-1:0] weight_table;

  // Sequencer and per-item registers.
  state_t             state, state_next;
  command_t           cmd;
  logic [INDEX_W-1:0] idx;
  logic [LIVE_W-1:0]  k, k_next;
  logic [LIVE_W-1:0]  rr_pointer, rr_pointer_next;
  logic [LIVE_W-1:0]  rr_p, rr_p_next;
  logic [LIVE_W-1:0]  chosen, chosen_next;
  logic               found, found_next;
  logic signed [SCORE_W-1:0] best_score, best_score_next;
  logic [COUNT_WIDTH-1:0]    best_conn, best_conn_next;
  logic [TOTAL_W-1:0]        total, total_next;
  logic               ev_valid;
  logic [LIVE_W-1:0]  ev_idx;
  logic [MAX_BACKENDS-1:0] health;

  // Memories, their valid bits and registered read data.
  logic signed [SCORE_W-1:0] score_mem [MAX_BACKENDS];
  logic [COUNT_WIDTH-1:0]    conn_mem  [MAX_BACKENDS];
  logic [MAX_BACKENDS-1:0]   score_valid, conn_valid;
  logic signed [SCORE_W-1:0] score_rd;
  logic [COUNT_WIDTH-1:0]    conn_rd;
  logic                      score_rd_valid, conn_rd_valid;

  // Memory port controls.
  logic                      score_we, conn_we, issue;
  logic [IDX_W-1:0]          score_raddr, score_waddr, conn_raddr, conn_waddr;
  logic signed [SCORE_W-1:0] score_wdata;
  logic [COUNT_WIDTH-1:0]    conn_wdata;
  logic                      health_we;
  logic                      finish;
  result_t                   fin_result;

  // Shared decode.
  logic [LIVE_W-1:0]  n_live;
  logic               mode_weighted, mode_least;
  logic               idx_in_range, cand_healthy, ev_healthy, walk_done, scan_last;
  logic [LIVE_W-1:0]  rr_adv;
  logic [SLOT_W-1:0]  weight;
  logic signed [SCORE_W-1:0] score_eff, score_upd, score_sub;
  logic [COUNT_WIDTH-1:0]    conn_eff;

  assign n_live = (int'(backend_count) > MAX_BACKENDS) ? LIVE_W'(MAX_BACKENDS) : backend_count;
  assign mode_weighted = (policy_mode == POL_WEIGHTED);
  assign mode_least    = (policy_mode == POL_LEAST);
  assign idx_in_range  = ({1'b0, idx} < n_live);
  assign cand_healthy  = health[IDX_W'(rr_p)];
  assign ev_healthy    = health[IDX_W'(ev_idx)];
  assign walk_done     = (k == n_live) && !ev_valid;
  assign scan_last     = (({1'b0, k} + 5'd1) == {1'b0, n_live});
  assign rr_adv = (({1'b0, rr_p} + 5'd1) == {1'b0, n_live}) ? '0 : rr_p + LIVE_W'(1);
  assign busy   = (state != S_IDLE);

  // Weight of the entry under evaluation; slots past the eighth weigh nothing.
  assign weight = ev_idx[LIVE_W-1] ? '0 : (weight_table[{ev_idx[2:0], 3'b000} +: SLOT_W] & WMASK);

  assign score_eff = score_rd_valid ? score_rd : '0;
  assign conn_eff  = conn_rd_valid ? conn_rd : '0;
  assign score_upd = sat_score({{(SUM_W-SCORE_W){score_eff[SCORE_W-1]}}, score_eff}
                               + {{(SUM_W-SLOT_W){1'b0}}, weight});
  assign score_sub = sat_score({{(SUM_W-SCORE_W){best_score[SCORE_W-1]}}, best_score}
                               - {{(SUM_W-TOTAL_W){1'b0}}, total});

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (cmd)
          CMD_PICK: begin
            if (n_live == '0) state_next = S_IDLE;
            else if (mode_weighted || mode_least) state_next = S_WALK;
            else state_next = S_RR_SCAN;
          end
          CMD_RELEASE: state_next = idx_in_range ? S_REL_RD : S_IDLE;
          default: state_next = S_IDLE;
        endcase
      end
      S_RR_SCAN: begin
        if (cand_healthy) state_next = S_INC_RD;
        else if (scan_last) state_next = S_IDLE;
      end
      S_WALK: begin
        if (walk_done) state_next = found ? S_INC_RD : S_IDLE;
      end
      S_INC_RD: state_next = S_INC_WR;
      S_INC_WR: state_next = S_IDLE;
      S_REL_RD: state_next = S_REL_WR;
      S_REL_WR: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Datapath controls and register updates for each sequencer step.
  always_comb begin
    k_next          = k;
    rr_p_next       = rr_p;
    rr_pointer_next = rr_pointer;
    chosen_next     = chosen;
    found_next      = found;
    best_score_next = best_score;
    best_conn_next  = best_conn;
    total_next      = total;
    issue           = 1'b0;
    score_we        = 1'b0;
    score_waddr     = '0;
    score_wdata     = score_upd;
    score_raddr     = '0;
    conn_we         = 1'b0;
    conn_waddr      = '0;
    conn_wdata      = '0;
    conn_raddr      = '0;
    health_we       = 1'b0;
    finish          = 1'b0;
    fin_result      = '{status: ST_OK, selected_backend: '0};
    unique case (state)
      S_IDLE: begin
      end
      S_DISPATCH: begin
        k_next     = '0;
        found_next = 1'b0;
        total_next = '0;
        rr_p_next  = (rr_pointer < n_live) ? rr_pointer : '0;
        unique case (cmd)
          CMD_PICK: begin
            if (n_live == '0) begin
              finish            = 1'b1;
              fin_result.status = ST_NO_BACKENDS;
            end
          end
          CMD_RELEASE: begin
            finish = !idx_in_range;
          end
          default: begin
            health_we = idx_in_range;
            finish    = 1'b1;
          end
        endcase
      end
      S_RR_SCAN: begin
        if (cand_healthy) begin
          chosen_next     = rr_p;
          rr_pointer_next = rr_adv;
        end else begin
          rr_p_next = rr_adv;
          k_next    = k + LIVE_W'(1);
          if (scan_last) begin
            finish            = 1'b1;
            fin_result.status = ST_NO_HEALTHY;
          end
        end
      end
      S_WALK: begin
        // Read entry k while the previous read is evaluated.
        issue = (k != n_live);
        if (issue) begin
          k_next      = k + LIVE_W'(1);
          score_raddr = IDX_W'(k);
          conn_raddr  = IDX_W'(k);
        end
        if (ev_valid && ev_healthy) begin
          if (mode_weighted) begin
            score_we    = 1'b1;
            score_waddr = IDX_W'(ev_idx);
            total_next  = total + TOTAL_W'(weight);
            if (!found || score_upd > best_score) begin
              found_next      = 1'b1;
              chosen_next     = ev_idx;
              best_score_next = score_upd;
            end
          end else if (!found || conn_eff < best_conn) begin
            found_next     = 1'b1;
            chosen_next    = ev_idx;
            best_conn_next = conn_eff;
          end
        end
        if (walk_done && !found) begin
          finish            = 1'b1;
          fin_result.status = ST_NO_HEALTHY;
        end
      end
      S_INC_RD: begin
        // Take the total weight off the weighted winner and fetch its count.
        conn_raddr = IDX_W'(chosen);
        if (mode_weighted) begin
          score_we    = 1'b1;
          score_waddr = IDX_W'(chosen);
          score_wdata = score_sub;
        end
      end
      S_INC_WR: begin
        conn_we    = 1'b1;
        conn_waddr = IDX_W'(chosen);
        conn_wdata = (conn_eff == '1) ? conn_eff : conn_eff + COUNT_WIDTH'(1);
        finish     = 1'b1;
        fin_result.selected_backend = chosen[INDEX_W-1:0];
      end
      S_REL_RD: begin
        conn_raddr = IDX_W'(idx);
      end
      S_REL_WR: begin
        conn_we    = 1'b1;
        conn_waddr = IDX_W'(idx);
        conn_wdata = (conn_eff == '0) ? conn_eff : conn_eff - COUNT_WIDTH'(1);
        finish     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers, configuration, health marks and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      done          <= 1'b0;
      ev_valid      <= 1'b0;
      rr_pointer    <= '0;
      policy_mode   <= POL_RR;
      backend_count <= LIVE_W'(1);
      weight_table  <= {(TABLE_W/SLOT_W){8'h01}};
      health        <= '1;
      score_valid   <= '0;
      conn_valid    <= '0;
    end else begin
      state      <= state_next;
      done       <= finish;
      ev_valid   <= issue;
      rr_pointer <= rr_pointer_next;
      if (health_we) health[IDX_W'(idx)] <= (cmd == CMD_MARK_UP);
      if (score_we) score_valid[score_waddr] <= 1'b1;
      if (conn_we) conn_valid[conn_waddr] <= 1'b1;
      if (cfg_write) begin
        if (cfg_index == REG_POLICY) policy_mode <= cfg_data[1:0];
        if (cfg_index == REG_WEIGHTS) weight_table <= cfg_data;
        if (cfg_index == REG_COUNT) begin
          backend_count <= cfg_data[LIVE_W-1:0];
          if (cfg_data[LIVE_W-1:0] != backend_count) score_valid <= '0;
        end
      end
    end
  end

  // Payload registers of the item in progress and the result beat.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd <= request.command;
      idx <= request.backend_index;
    end
    k          <= k_next;
    rr_p       <= rr_p_next;
    chosen     <= chosen_next;
    found      <= found_next;
    best_score <= best_score_next;
    best_conn  <= best_conn_next;
    total      <= total_next;
    ev_idx     <= k;
    if (finish) result <= fin_result;
  end

  // Score memory: one write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (score_we) score_mem[score_waddr] <= score_wdata;
    score_rd       <= score_mem[score_raddr];
    score_rd_valid <= score_valid[score_raddr];
  end

  // Connection count memory: one write and one registered read each cycle.
  always_ff @(posedge clk) begin
    if (conn_we) conn_mem[conn_waddr] <= conn_wdata;
    conn_rd       <= conn_mem[conn_raddr];
    conn_rd_valid <= conn_valid[conn_raddr];
  end

  // A result beat only appears once the sequencer is back in idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while the sequencer is busy");

  // An accepted command keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted command did not start the sequencer");

  // Failed results carry backend zero; non-pick results do too, but only failures are checked.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
      (done && result.status != ST_OK) |-> (result.selected_backend == '0))
    else $error("failed pick reports a backend");

  // The walk counter never passes the number of live backends.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
      (state == S_WALK || state == S_RR_SCAN) |-> (k <= n_live))
    else $error("walk counter beyond live backends");

  // A chosen backend is always one of the live entries.
  a_chosen_live: assert property (@(posedge clk) disable iff (rst)
      (state == S_INC_RD) |-> (chosen < n_live && health[IDX_W'(chosen)]))
    else $error("chosen backend is not a healthy live entry");

endmodule

/* dv/backend_selector_test.sv */
// Self-checking testbench for the backend selector: directed and random command beats.
module backend_selector_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bsel_pkg::*;

  localparam int LIVE_MAX    = 8;
  localparam int SCORE_HI    = 32767;
  localparam int SCORE_LO    = -32768;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 12;
  localparam int PHASE_BEATS = 120;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  request_t             request = '0;
  logic                 done;
  result_t              result;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TABLE_W-1:0]   cfg_data = '0;

  // Command beats waiting to be driven, and selections still owed by the block.
  request_t queued_requests[$];
  result_t  selections_due[$];
  int       requests_sent = 0;
  int       requests_taken = 0;
  int       idle_pct = 37;
  int       fail_count = 0;
  int       cycle_count = 0;

  // Predicted selector state and register copies.
  logic [1:0]         policy_reg = POL_RR;
  logic [3:0]         count_reg = 4'd1;
  logic [TABLE_W-1:0] weight_reg = 64'h0101_0101_0101_0101;
  int                 rr_next = 0;
  int                 score[LIVE_MAX] = '{default: 0};
  logic [15:0]        open_conns[LIVE_MAX] = '{default: '0};
  bit                 healthy[LIVE_MAX] = '{default: 1'b1};

  backend_selector dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .done     (done),
    .result   (result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int clamp_score(int v);
    if (v > SCORE_HI) return SCORE_HI;
    if (v < SCORE_LO) return SCORE_LO;
    return v;
  endfunction

  // Works out the result of one command beat and advances the predicted state.
  function automatic result_t choose_backend(request_t req);
    result_t res;
    int      live;
    int      pick;
    int      total;
    int      best;
    int      w;
    int      pos;
    int      cand;
    int      i;
    res.status = ST_OK;
    res.selected_backend = '0;
    live = (count_reg > LIVE_MAX) ? LIVE_MAX : int'(count_reg);
    pick = -1;
    best = 0;
    if (req.command == CMD_PICK) begin
      if (live == 0) begin
        res.status = ST_NO_BACKENDS;
      end else begin
        if (policy_reg == POL_WEIGHTED) begin
          // Smooth weighted: raise every healthy score, the highest wins and pays the total.
          total = 0;
          for (i = 0; i < live; i++) begin
            if (healthy[i]) begin
              w = int'(weight_reg[8*i +: 8]);
              total += w;
              score[i] = clamp_score(score[i] + w);
              if (pick < 0 || score[i] > best) begin
                best = score[i];
                pick = i;
              end
            end
          end
          if (pick >= 0) score[pick] = clamp_score(score[pick] - total);
        end else if (policy_reg == POL_LEAST) begin
          for (i = 0; i < live; i++) begin
            if (healthy[i] && (pick < 0 || open_conns[i] < open_conns[pick])) pick = i;
          end
        end else begin
          // Round robin; a pointer past the live count starts over at entry zero.
          pos = (rr_next < live) ? rr_next : 0;
          for (i = 0; i < live && pick < 0; i++) begin
            cand = pos;
            pos = (pos + 1 == live) ? 0 : pos + 1;
            if (healthy[cand]) begin
              pick = cand;
              rr_next = pos;
            end
          end
        end
        if (pick < 0) begin
          res.status = ST_NO_HEALTHY;
        end else begin
          if (open_conns[pick] != '1) open_conns[pick]++;
          res.selected_backend = 3'(pick);
        end
      end
    end else if (req.backend_index < live) begin
      if (req.command == CMD_RELEASE) begin
        if (open_conns[req.backend_index] != '0) open_conns[req.backend_index]--;
      end else begin
        healthy[req.backend_index] = (req.command == CMD_MARK_UP);
      end
    end
    return res;
  endfunction

  // Register write on the config port, mirrored into the predicted registers.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [TABLE_W-1:0] value);
    int i;
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_POLICY: begin
        policy_reg = value[1:0];
      end
      REG_COUNT: begin
        // A new backend count wipes the weighted scores.
        if (value[3:0] != count_reg) begin
          for (i = 0; i < LIVE_MAX; i++) score[i] = 0;
        end
        count_reg = value[3:0];
      end
      REG_WEIGHTS: begin
        weight_reg = value;
      end
      default: begin
      end
    endcase
  endtask

  task automatic queue_request(input command_t cmd, input int idx);
    request_t req;
    req.command = cmd;
    req.backend_index = 3'(idx);
    queued_requests = {queued_requests, req};
  endtask

  // Blocks until every queued beat is taken, answered and the block is idle.
  task automatic wait_idle(input int settle);
    while (queued_requests.size() != 0 || requests_sent != requests_taken ||
           selections_due.size() != 0 || busy) begin
      @(negedge clk);
    end
    repeat (settle) @(negedge clk);
  endtask

  // Driver: a new beat is offered only once the previous one has been taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (requests_sent == requests_taken) begin
      if (queued_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
        request <= queued_requests.pop_front();
        start <= 1'b1;
        requests_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks result beats, then predicts for a command beat taken at this edge.
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (done) begin
        if (selections_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got status %0d backend %0d",
                   $time, result.status, result.selected_backend);
          fail_count++;
        end else begin
          want = selections_due.pop_front();
          if (result.status !== want.status) begin
            $display("%0t ns: status mismatch, expected %0d, got %0d",
                     $time, want.status, result.status);
            fail_count++;
          end
          if (result.selected_backend !== want.selected_backend) begin
            $display("%0t ns: selected_backend mismatch, expected %0d, got %0d",
                     $time, want.selected_backend, result.selected_backend);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        selections_due = {selections_due, choose_backend(request)};
        requests_taken++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int               phase;
    int               k;
    int               roll;
    logic [TABLE_W-1:0] data;
    request_t         req;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: one round robin backend, release at zero, out-of-range and failed picks.
    queue_request(CMD_PICK, 0);
    queue_request(CMD_RELEASE, 0);
    queue_request(CMD_RELEASE, 0);
    queue_request(CMD_MARK_DOWN, 7);
    queue_request(CMD_PICK, 5);
    queue_request(CMD_MARK_DOWN, 0);
    queue_request(CMD_PICK, 0);
    queue_request(CMD_MARK_UP, 0);
    queue_request(CMD_PICK, 7);
    wait_idle(3);

    // No backends configured.
    write_register(REG_COUNT, 64'd0);
    queue_request(CMD_PICK, 0);
    queue_request(CMD_RELEASE, 3);
    wait_idle(3);

    // Oversized count with the unused policy code, then a shrink that strands the pointer.
    write_register(REG_COUNT, '1);
    write_register(REG_POLICY, '1);
    repeat (6) queue_request(CMD_PICK, 0);
    wait_idle(3);
    write_register(REG_COUNT, 64'd3);
    write_register(REG_POLICY, 64'(POL_RR));
    queue_request(CMD_PICK, 2);
    wait_idle(3);

    // Smooth weighted with extreme weights, then least connections.
    write_register(REG_WEIGHTS, 64'h5A3C_9612_0180_00FF);
    write_register(REG_COUNT, 64'd4);
    write_register(REG_POLICY, 64'(POL_WEIGHTED));
    repeat (3) queue_request(CMD_PICK, 0);
    wait_idle(3);
    write_register(REG_POLICY, 64'(POL_LEAST));
    queue_request(CMD_MARK_DOWN, 1);
    queue_request(CMD_PICK, 0);
    queue_request(CMD_PICK, 0);
    queue_request(CMD_RELEASE, 0);
    wait_idle(3);

    // Random phases: half picks, the rest releases and health changes at random indexes.
    for (phase = 0; phase < PHASES; phase++) begin
      idle_pct = (phase == 5) ? 0 : 37;
      if (phase == 0) write_register(REG_SPARE, '1);
      if (phase < 4 || $urandom_range(9) < 7) begin
        data = {$urandom, $urandom};
        data[1:0] = (phase < 4) ? 2'(phase) : 2'($urandom_range(3));
        write_register(REG_POLICY, data);
      end
      if (phase < 6 || $urandom_range(9) < 7) begin
        data = {$urandom, $urandom};
        case (phase)
          0: data[3:0] = 4'd8;
          1: data[3:0] = 4'd15;
          2: data[3:0] = 4'd2;
          3: data[3:0] = 4'd1;
          4: data[3:0] = 4'd0;
          5: data[3:0] = 4'd8;
          default: begin
            data[3:0] = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                  : 4'($urandom_range(8, 2));
          end
        endcase
        write_register(REG_COUNT, data);
      end
      if (phase < 3 || $urandom_range(9) < 7) begin
        for (k = 0; k < 8; k++) begin
          roll = $urandom_range(3);
          data[8*k +: 8] = (roll == 0) ? 8'hFF : (roll == 1) ? 8'h00 : 8'($urandom);
        end
        if (phase == 1) data = '1;
        if (phase == 2) data = '0;
        write_register(REG_WEIGHTS, data);
      end
      for (k = 0; k < PHASE_BEATS; k++) begin
        roll = $urandom_range(99);
        if (roll < 50) begin
          req.command = CMD_PICK;
        end else if (roll < 70) begin
          req.command = CMD_RELEASE;
        end else if (roll < 85) begin
          req.command = CMD_MARK_DOWN;
        end else begin
          req.command = CMD_MARK_UP;
        end
        req.backend_index = 3'($urandom_range(7));
        queued_requests = {queued_requests, req};
      end
      wait_idle(3);
    end

    wait_idle(20);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
